### hw/rtl/mm3_pkg.sv
// Shared types, codes and mixing constants for the chained 128-bit hash block.
package mm3_pkg;

  localparam logic [1:0] MODE_HASH  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  localparam logic [4:0] BLOCK_BYTES = 5'd16;

  localparam logic [63:0] MIX_C1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] ADD_H1  = 64'h0000000052dce729;
  localparam logic [63:0] ADD_H2  = 64'h0000000038495ab5;
  localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] word_first;
    logic [63:0] word_second;
    logic [4:0]  valid_bytes;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_first;
    logic [63:0] digest_second;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_LOAD,
    KIND_BLOCK,
    KIND_FINAL_FULL,
    KIND_FINAL_TAIL
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  count;
    logic [63:0] word_a;
    logic [63:0] word_b;
  } cmd_t;

endpackage

### hw/rtl/mm3_front.sv
// Input stage: accepts transactions, classifies them and masks tail bytes.
module mm3_front import mm3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_full
);

  logic       valid_r;
  logic       valid_nxt;
  cmd_t       cmd_r;
  cmd_t       cmd_nxt;
  logic       acc;
  logic       fwd;
  logic [4:0] cnt_sat;
  logic [3:0] n_first;
  logic [3:0] n_second;

  function automatic logic [63:0] byte_mask(logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  assign fwd       = valid_r && !cmd_full;
  assign in_full   = valid_r && cmd_full;
  assign acc       = in_push && !in_full;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    cnt_sat  = (in_item.valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : in_item.valid_bytes;
    n_first  = (cnt_sat >= 5'd8) ? 4'd8 : cnt_sat[3:0];
    n_second = (cnt_sat > 5'd8) ? 4'(cnt_sat - 5'd8) : 4'd0;
    cmd_nxt.kind   = KIND_BLOCK;
    cmd_nxt.count  = BLOCK_BYTES;
    cmd_nxt.word_a = in_item.word_first;
    cmd_nxt.word_b = in_item.word_second;
    case (in_item.mode)
      MODE_CLEAR: begin
        cmd_nxt.kind = KIND_CLEAR;
      end
      MODE_LOAD: begin
        cmd_nxt.kind = KIND_LOAD;
      end
      default: begin
        if (in_item.last_block) begin
          cmd_nxt.count = cnt_sat;
          if (cnt_sat == BLOCK_BYTES) begin
            cmd_nxt.kind = KIND_FINAL_FULL;
          end else begin
            cmd_nxt.kind   = KIND_FINAL_TAIL;
            cmd_nxt.word_a = in_item.word_first & byte_mask(n_first);
            cmd_nxt.word_b = in_item.word_second & byte_mask(n_second);
          end
        end
      end
    endcase
  end

  always_comb begin
    if (acc) begin
      valid_nxt = (in_item.mode == MODE_HASH) || (in_item.mode == MODE_CLEAR) ||
                  (in_item.mode == MODE_LOAD);
    end else begin
      valid_nxt = valid_r && !fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (acc) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

### hw/rtl/mm3_queue.sv
// Short command queue between the input stage and the hash engine.
module mm3_queue import mm3_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  cmd_t din,
  input  logic pop,
  output logic empty,
  output cmd_t dout
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> !empty) else $error("queue empty after a push");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

### hw/rtl/mm3_mul.sv
// Iterative 64x64 multiplier, low half of the product, one 32x32 partial product a cycle.
module mm3_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  typedef enum logic [1:0] {MS_IDLE, MS_LL, MS_HL, MS_LH} step_t;

  step_t       step_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] p_r;
  logic        done_r;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod;

  assign done = done_r;
  assign p    = p_r;

  always_comb begin
    op_x = (step_r == MS_HL) ? a_r[63:32] : a_r[31:0];
    op_y = (step_r == MS_LH) ? b_r[63:32] : b_r[31:0];
    prod = 64'(op_x) * 64'(op_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= MS_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (step_r)
        MS_IDLE: begin
          if (start) begin
            a_r    <= a;
            b_r    <= b;
            step_r <= MS_LL;
          end
        end
        MS_LL: begin
          p_r    <= prod;
          step_r <= MS_HL;
        end
        MS_HL: begin
          p_r[63:32] <= p_r[63:32] + prod[31:0];
          step_r     <= MS_LH;
        end
        MS_LH: begin
          p_r[63:32] <= p_r[63:32] + prod[31:0];
          step_r     <= MS_IDLE;
          done_r     <= 1'b1;
        end
        default: begin
          step_r <= MS_IDLE;
        end
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> step_r == MS_IDLE) else $error("multiply started while busy");

endmodule

### hw/rtl/mm3_back.sv
// Hash engine: body and tail mix, finalisation, digest state and result register.
module mm3_back import mm3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_K1A, ST_K1B, ST_K2A, ST_K2B, ST_TAIL,
    ST_MIX1, ST_MIX2, ST_MIX3, ST_MIX4, ST_FIN1, ST_FIN2,
    ST_F1A, ST_F1B, ST_F2A, ST_F2B, ST_FIN3, ST_FIN4, ST_EMIT
  } state_t;

  state_t      state_r;
  kind_t       kind_r;
  logic [63:0] w1_r;
  logic [63:0] w2_r;
  logic [63:0] k1_r;
  logic [63:0] k2_r;
  logic [63:0] h1_r;
  logic [63:0] h2_r;
  logic [63:0] saved1_r;
  logic [63:0] saved2_r;
  logic [63:0] bt_r;
  logic        in_msg_r;
  logic        issued_r;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        mul_state;
  logic        mul_start;
  logic        mul_done;
  logic        mul_adv;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] mul_p;
  logic        is_final;
  logic        slot_free;

  function automatic logic [63:0] shr_mix(logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

  function automatic logic [63:0] rotl(logic [63:0] v, int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  assign mul_state = (state_r == ST_K1A) || (state_r == ST_K1B) || (state_r == ST_K2A) ||
                     (state_r == ST_K2B) || (state_r == ST_F1A) || (state_r == ST_F1B) ||
                     (state_r == ST_F2A) || (state_r == ST_F2B);
  assign mul_start = mul_state && !issued_r;
  assign mul_adv   = issued_r && mul_done;
  assign is_final  = (kind_r == KIND_FINAL_FULL) || (kind_r == KIND_FINAL_TAIL);
  assign slot_free = !out_valid_r || out_pop;
  assign cmd_pop   = (state_r == ST_IDLE) && !cmd_empty;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_K1A: begin
        mul_a = w1_r;
        mul_b = MIX_C1;
      end
      ST_K1B: begin
        mul_a = rotl(mul_p, 31);
        mul_b = MIX_C2;
      end
      ST_K2A: begin
        mul_a = w2_r;
        mul_b = MIX_C2;
      end
      ST_K2B: begin
        mul_a = rotl(mul_p, 33);
        mul_b = MIX_C1;
      end
      ST_F1A: begin
        mul_a = shr_mix(h1_r);
        mul_b = FMIX_M1;
      end
      ST_F2A: begin
        mul_a = shr_mix(h2_r);
        mul_b = FMIX_M1;
      end
      ST_F1B, ST_F2B: begin
        mul_a = shr_mix(mul_p);
        mul_b = FMIX_M2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mm3_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      in_msg_r    <= 1'b0;
      saved1_r    <= '0;
      saved2_r    <= '0;
      h1_r        <= '0;
      h2_r        <= '0;
      bt_r        <= '0;
    end else begin
      if (state_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      if (mul_start) begin
        issued_r <= 1'b1;
      end else if (mul_done) begin
        issued_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!cmd_empty) begin
            case (cmd.kind)
              KIND_CLEAR, KIND_LOAD: begin
                saved1_r <= (cmd.kind == KIND_LOAD) ? cmd.word_a : '0;
                saved2_r <= (cmd.kind == KIND_LOAD) ? cmd.word_b : '0;
                h1_r     <= '0;
                h2_r     <= '0;
                bt_r     <= '0;
                in_msg_r <= 1'b0;
              end
              default: begin
                kind_r   <= cmd.kind;
                w1_r     <= cmd.word_a;
                w2_r     <= cmd.word_b;
                in_msg_r <= 1'b1;
                if (!in_msg_r) begin
                  h1_r <= saved1_r;
                  h2_r <= saved2_r;
                end
                bt_r    <= (in_msg_r ? bt_r : 64'd0) + 64'(cmd.count);
                state_r <= ST_K1A;
              end
            endcase
          end
        end
        ST_K1A: begin
          if (mul_adv) state_r <= ST_K1B;
        end
        ST_K1B: begin
          if (mul_adv) begin
            k1_r    <= mul_p;
            state_r <= ST_K2A;
          end
        end
        ST_K2A: begin
          if (mul_adv) state_r <= ST_K2B;
        end
        ST_K2B: begin
          if (mul_adv) begin
            k2_r    <= mul_p;
            state_r <= (kind_r == KIND_FINAL_TAIL) ? ST_TAIL : ST_MIX1;
          end
        end
        ST_TAIL: begin
          h1_r    <= h1_r ^ k1_r;
          h2_r    <= h2_r ^ k2_r;
          state_r <= ST_FIN1;
        end
        ST_MIX1: begin
          h1_r    <= rotl(h1_r ^ k1_r, 27) + h2_r;
          state_r <= ST_MIX2;
        end
        ST_MIX2: begin
          h1_r    <= (h1_r << 2) + h1_r + ADD_H1;
          state_r <= ST_MIX3;
        end
        ST_MIX3: begin
          h2_r    <= rotl(h2_r ^ k2_r, 31) + h1_r;
          state_r <= ST_MIX4;
        end
        ST_MIX4: begin
          h2_r    <= (h2_r << 2) + h2_r + ADD_H2;
          state_r <= is_final ? ST_FIN1 : ST_IDLE;
        end
        ST_FIN1: begin
          h1_r    <= (h1_r ^ bt_r) + (h2_r ^ bt_r);
          h2_r    <= h2_r ^ bt_r;
          state_r <= ST_FIN2;
        end
        ST_FIN2: begin
          h2_r    <= h2_r + h1_r;
          state_r <= ST_F1A;
        end
        ST_F1A: begin
          if (mul_adv) state_r <= ST_F1B;
        end
        ST_F1B: begin
          if (mul_adv) begin
            h1_r    <= shr_mix(mul_p);
            state_r <= ST_F2A;
          end
        end
        ST_F2A: begin
          if (mul_adv) state_r <= ST_F2B;
        end
        ST_F2B: begin
          if (mul_adv) begin
            h2_r    <= shr_mix(mul_p);
            state_r <= ST_FIN3;
          end
        end
        ST_FIN3: begin
          h1_r    <= h1_r + h2_r;
          state_r <= ST_FIN4;
        end
        ST_FIN4: begin
          h2_r    <= h2_r + h1_r;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_item_r.digest_first  <= h1_r;
            out_item_r.digest_second <= h2_r;
            saved1_r                 <= h1_r;
            saved2_r                 <= h2_r;
            bt_r                     <= '0;
            in_msg_r                 <= 1'b0;
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_K1A) || (state_r == ST_K1B) || (state_r == ST_K2A) ||
                 (state_r == ST_K2B) || (state_r == ST_F1A) || (state_r == ST_F1B) ||
                 (state_r == ST_F2A) || (state_r == ST_F2B))
    else $error("multiply finished outside a multiply step");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && slot_free) |=> out_valid_r && !in_msg_r)
    else $error("result not registered on emit");

endmodule

### hw/rtl/murmur3_128_chained_hash_top.sv
// Top level of the chained 128-bit hash block: input stage, command queue, hash engine.
//
//   channel  direction  handshake         payload
//   in_      input      in_push / in_full     in_item_t
//   out_     output     out_pop / out_empty   out_item_t
//
// Multiplier: the engine shares one 32x32 multiplier for key mixing and finalisation.
// Clear and load are handled in the idle state; mode three is dropped at the input stage.
// Reset: synchronous, active low; chaining seed and running state clear to zero.
// Stalls: the command queue lets the input side run ahead; a waiting result holds the engine
// only at the end of finalisation.
module murmur3_128_chained_hash_top import mm3_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic cmd_valid;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_empty;
  cmd_t cmd_head;
  logic cmd_pop;

  mm3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full)
  );

  mm3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_valid),
    .full  (cmd_full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_head)
  );

  mm3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### verif/tb_murmur3_128_chained_hash_top.sv
// Self-checking testbench for the chained 128-bit MurmurHash3 block with a built-in digest predictor.
`timescale 1ns / 100ps

module tb_murmur3_128_chained_hash_top;
  import mm3_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [63:0] KEY_MUL_A  = 64'h87c37b91114253d5;
  localparam logic [63:0] KEY_MUL_B  = 64'h4cf5ad432745937f;
  localparam logic [63:0] STEP_ADD_A = 64'h0000000052dce729;
  localparam logic [63:0] STEP_ADD_B = 64'h0000000038495ab5;
  localparam logic [63:0] AVAL_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] AVAL_MUL_B = 64'hc4ceb9fe1a85ec53;

  localparam int ITEM_TARGET     = 1925;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 200;
  localparam int STALL_LIMIT     = 4000;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  pending_t  pending_items[$];
  out_item_t digest_expected[$];

  logic [63:0] seed_first = '0;
  logic [63:0] seed_second = '0;
  logic [63:0] acc_first = '0;
  logic [63:0] acc_second = '0;
  logic [63:0] msg_bytes = '0;
  bit          msg_open = 1'b0;

  int error_count  = 0;
  int queued_count = 0;
  int push_idle    = 0;
  int pop_wait     = 0;
  int digests_seen = 0;
  int idle_cycles  = 0;

  murmur3_128_chained_hash_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] avalanche(input logic [63:0] v);
    v = v ^ (v >> 33);
    v = v * AVAL_MUL_A;
    v = v ^ (v >> 33);
    v = v * AVAL_MUL_B;
    v = v ^ (v >> 33);
    return v;
  endfunction

  function automatic logic [63:0] scramble_first(input logic [63:0] k);
    k = k * KEY_MUL_A;
    k = rotl64(k, 31);
    return k * KEY_MUL_B;
  endfunction

  function automatic logic [63:0] scramble_second(input logic [63:0] k);
    k = k * KEY_MUL_B;
    k = rotl64(k, 33);
    return k * KEY_MUL_A;
  endfunction

  function automatic logic [63:0] keep_low_bytes(input logic [63:0] v, input int unsigned n);
    if (n >= 8) return v;
    return v & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic void absorb_block(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] h1;
    logic [63:0] h2;
    h1 = acc_first;
    h2 = acc_second;
    h1 = h1 ^ scramble_first(a);
    h1 = rotl64(h1, 27);
    h1 = h1 + h2;
    h1 = h1 * 5 + STEP_ADD_A;
    h2 = h2 ^ scramble_second(b);
    h2 = rotl64(h2, 31);
    h2 = h2 + h1;
    h2 = h2 * 5 + STEP_ADD_B;
    acc_first = h1;
    acc_second = h2;
  endfunction

  task automatic predict_digest(input in_item_t it);
    logic [4:0]  n;
    logic [63:0] h1;
    logic [63:0] h2;
    out_item_t   want;
    case (it.mode)
      MODE_CLEAR, MODE_LOAD: begin
        seed_first  = (it.mode == MODE_LOAD) ? it.word_first : '0;
        seed_second = (it.mode == MODE_LOAD) ? it.word_second : '0;
        acc_first   = '0;
        acc_second  = '0;
        msg_bytes   = '0;
        msg_open    = 1'b0;
      end
      MODE_HASH: begin
        if (!msg_open) begin
          acc_first  = seed_first;
          acc_second = seed_second;
          msg_bytes  = '0;
          msg_open   = 1'b1;
        end
        if (!it.last_block) begin
          absorb_block(it.word_first, it.word_second);
          msg_bytes = msg_bytes + 64'd16;
        end else begin
          n = (it.valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : it.valid_bytes;
          msg_bytes = msg_bytes + n;
          if (n == BLOCK_BYTES) begin
            absorb_block(it.word_first, it.word_second);
          end else begin
            if (n > 8) acc_second = acc_second ^ scramble_second(keep_low_bytes(it.word_second, n - 8));
            if (n > 0) acc_first = acc_first ^ scramble_first(keep_low_bytes(it.word_first, n));
          end
          h1 = acc_first ^ msg_bytes;
          h2 = acc_second ^ msg_bytes;
          h1 = h1 + h2;
          h2 = h2 + h1;
          h1 = avalanche(h1);
          h2 = avalanche(h2);
          h1 = h1 + h2;
          h2 = h2 + h1;
          seed_first  = h1;
          seed_second = h2;
          acc_first   = h1;
          acc_second  = h2;
          msg_bytes   = '0;
          msg_open    = 1'b0;
          want.digest_first  = h1;
          want.digest_second = h2;
          digest_expected.push_back(want);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_digest(input out_item_t got);
    out_item_t want;
    if (digest_expected.size() == 0) begin
      report_mismatch("digest with no pending transaction", got.digest_first, '0);
    end else begin
      want = digest_expected.pop_front();
      if (got.digest_first !== want.digest_first)
        report_mismatch("digest_first", got.digest_first, want.digest_first);
      if (got.digest_second !== want.digest_second)
        report_mismatch("digest_second", got.digest_second, want.digest_second);
    end
  endtask

  function automatic logic [63:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic queue_item(input logic [1:0] mode, input logic [63:0] w1, input logic [63:0] w2,
                            input logic [4:0] valid, input logic last, input bit drain);
    pending_t p;
    p.item.mode        = mode;
    p.item.word_first  = w1;
    p.item.word_second = w2;
    p.item.valid_bytes = valid;
    p.item.last_block  = last;
    p.gap   = ((queued_count % 120) < 30) ? 0 : $urandom_range(0, 9);
    p.drain = drain;
    pending_items.push_back(p);
    queued_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!(in_push && in_full)) begin
      if (in_push) begin
        predict_digest(in_item);
        push_idle = 0;
      end
      if (pending_items.size() > 0 && push_idle >= pending_items[0].gap &&
          !(pending_items[0].drain && digest_expected.size() > 0)) begin
        in_item <= pending_items[0].item;
        pending_items.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
        push_idle++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        check_digest(out_item);
        digests_seen++;
        pop_wait = ((digests_seen % 48) < 16) ? 0 : $urandom_range(0, 9);
        if (digests_seen == 30 || digests_seen == 320) pop_wait = HOLD_OFF_CYCLES;
      end else if (!out_pop && pop_wait > 0) begin
        pop_wait--;
      end
      out_pop <= (pop_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t stalled for %0d cycles", $realtime, idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned nblk;
    int unsigned r;
    int          work_count;
    bit          drain_flag;

    // directed: extremes, tail lengths, saturation, clear and load in and out of a message
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd0, 1'b1, 1'b0);
    queue_item(MODE_HASH, '1, '1, 5'd16, 1'b1, 1'b0);
    queue_item(MODE_HASH, '0, '0, 5'd16, 1'b1, 1'b0);
    queue_item(MODE_HASH, '1, '1, 5'd1, 1'b1, 1'b0);
    queue_item(MODE_HASH, '1, '1, 5'd7, 1'b1, 1'b0);
    queue_item(MODE_HASH, '1, '1, 5'd8, 1'b1, 1'b0);
    queue_item(MODE_HASH, '1, '1, 5'd9, 1'b1, 1'b0);
    queue_item(MODE_HASH, '1, '1, 5'd15, 1'b1, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd17, 1'b1, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd31, 1'b1, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd0, 1'b0, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd5, 1'b0, 1'b0);
    queue_item(MODE_HASH, '1, '1, 5'd12, 1'b1, 1'b0);
    queue_item(MODE_CLEAR, '1, '1, 5'd31, 1'b1, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd16, 1'b1, 1'b0);
    queue_item(MODE_LOAD, '1, '1, 5'd0, 1'b0, 1'b0);
    queue_item(MODE_HASH, '1, '1, 5'd3, 1'b1, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd16, 1'b0, 1'b0);
    queue_item(MODE_CLEAR, '0, '0, 5'd0, 1'b0, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd16, 1'b1, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd16, 1'b0, 1'b0);
    queue_item(MODE_LOAD, {$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b1, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd0, 1'b1, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd16, 1'b0, 1'b0);
    queue_item(MODE_NONE, '1, '1, 5'd31, 1'b1, 1'b0);
    queue_item(MODE_HASH, pick_word(), pick_word(), 5'd10, 1'b1, 1'b0);

    work_count = 0;
    drain_flag = 1'b1;
    while (work_count < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        for (int i = 1; i < nblk; i++) begin
          queue_item(MODE_HASH, pick_word(), pick_word(), 5'($urandom_range(0, 31)), 1'b0,
                     drain_flag);
          drain_flag = 1'b0;
          work_count++;
        end
        queue_item(MODE_HASH, pick_word(), pick_word(),
                   5'(($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                  : $urandom_range(0, 16)),
                   1'b1, drain_flag);
        drain_flag = 1'b0;
        work_count++;
      end else if (r < 86) begin
        nblk = $urandom_range(1, 3);
        for (int i = 0; i < nblk; i++) begin
          queue_item(MODE_HASH, pick_word(), pick_word(), 5'($urandom_range(0, 31)), 1'b0, 1'b0);
          work_count++;
        end
        queue_item($urandom_range(0, 1) ? MODE_CLEAR : MODE_LOAD, pick_word(), pick_word(),
                   5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'b0);
        work_count++;
      end else if (r < 92) begin
        queue_item(MODE_CLEAR, pick_word(), pick_word(), 5'($urandom_range(0, 31)),
                   1'($urandom_range(0, 1)), 1'b0);
        work_count++;
      end else if (r < 97) begin
        queue_item(MODE_LOAD, pick_word(), pick_word(), 5'($urandom_range(0, 31)),
                   1'($urandom_range(0, 1)), 1'b0);
        work_count++;
      end else begin
        queue_item(MODE_NONE, pick_word(), pick_word(), 5'($urandom_range(0, 31)),
                   1'($urandom_range(0, 1)), 1'b0);
      end
      if (work_count >= ITEM_TARGET / 2 && work_count < ITEM_TARGET / 2 + 6) drain_flag = 1'b1;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_push) @(posedge clk);
    while (digest_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && digest_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mm3_pkg.sv
hw/rtl/mm3_front.sv
hw/rtl/mm3_queue.sv
hw/rtl/mm3_mul.sv
hw/rtl/mm3_back.sv
hw/rtl/murmur3_128_chained_hash_top.sv
verif/tb_murmur3_128_chained_hash_top.sv
